### rtl/order_book_price_level_table_macros.svh
// Assertion macros for the order book price level table.
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_MACROS_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define OBPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define OBPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OBPL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define OBPL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/obpl_pkg.sv
package obpl_pkg;
   localparam int LEVELS     = 64;
   localparam int PRICE_BITS = 32;
   localparam int QTY_BITS   = 31;
   localparam int CNT_BITS   = $clog2(LEVELS + 1);

   typedef struct packed {
      logic                  is_ask;
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   qty;
      logic                  negative;
   } upd_type;

   // per-cell command, broadcast to every cell of one side
   typedef struct packed {
      logic                  en;
      logic                  is_ask;
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   qty;
      logic                  do_insert;
      logic                  do_remove;
      logic                  do_write;
      logic [CNT_BITS-1:0]   pos;
   } cmd_type;
endpackage

### rtl/obpl_cell.sv
module obpl_cell import obpl_pkg::*; (
   input  logic                  clock,
   input  logic [CNT_BITS-1:0]   index,
   input  logic                  occupied,
   input  cmd_type               cmd,
   input  logic [PRICE_BITS-1:0] left_price,
   input  logic [QTY_BITS-1:0]   left_qty,
   input  logic [PRICE_BITS-1:0] right_price,
   input  logic [QTY_BITS-1:0]   right_qty,
   output logic [PRICE_BITS-1:0] price,
   output logic [QTY_BITS-1:0]   qty,
   output logic                  before_new,
   output logic                  match
);
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [QTY_BITS-1:0]   qty_ff, qty_in;

   assign price = price_ff;
   assign qty   = qty_ff;
   assign before_new = occupied &&
      (cmd.is_ask ? (price_ff < cmd.price) : (price_ff > cmd.price));
   assign match = occupied && (price_ff == cmd.price);

   always_comb begin
      price_in = price_ff;
      qty_in   = qty_ff;
      if (cmd.en) begin
         if (cmd.do_insert) begin
            if (index == cmd.pos) begin
               price_in = cmd.price;
               qty_in   = cmd.qty;
            end else if (index > cmd.pos) begin
               price_in = left_price;
               qty_in   = left_qty;
            end
         end else if (cmd.do_remove) begin
            if (index >= cmd.pos) begin
               price_in = right_price;
               qty_in   = right_qty;
            end
         end else if (cmd.do_write && index == cmd.pos) begin
            qty_in = cmd.qty;
         end
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end
endmodule

### rtl/obpl_side.sv
module obpl_side import obpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sel,
   input  cmd_type               cmd,
   output logic [CNT_BITS-1:0]   count,
   output logic [CNT_BITS-1:0]   pos,
   output logic                  found,
   output logic [PRICE_BITS-1:0] top_price,
   output logic [QTY_BITS-1:0]   top_qty
);
   logic [PRICE_BITS-1:0] pr [LEVELS];
   logic [QTY_BITS-1:0]   qt [LEVELS];
   logic [LEVELS-1:0]     bef, mat;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   cmd_type               c;

   always_comb begin
      c = cmd;
      c.en = cmd.en && sel;
   end

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      obpl_cell u_cell (
         .clock(clock), .index(CNT_BITS'(i)), .occupied(CNT_BITS'(i) < count_ff),
         .cmd(c),
         .left_price(pr[(i == 0) ? 0 : i-1]), .left_qty(qt[(i == 0) ? 0 : i-1]),
         .right_price(pr[(i == LEVELS-1) ? i : i+1]),
         .right_qty(qt[(i == LEVELS-1) ? i : i+1]),
         .price(pr[i]), .qty(qt[i]), .before_new(bef[i]), .match(mat[i])
      );
   end

   // sorted chain: before_new bits form a prefix, so pos is its popcount
   assign pos   = CNT_BITS'($countones(bef));
   assign found = |(mat & ~bef & (LEVELS'(1) << pos[$clog2(LEVELS)-1:0]))
                  && (pos < count_ff);
   assign count = count_ff;
   assign top_price = pr[0];
   assign top_qty   = qt[0];

   always_comb begin
      count_in = count_ff;
      if (c.en) begin
         if (c.do_insert) count_in = count_ff + 1'b1;
         else if (c.do_remove) count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end
endmodule

### rtl/order_book_price_level_table.sv
// Two sorted price-level tables (bids best-high, asks best-low), each a chain
// of LEVELS cells that shift toward or away from the head on insert or delete.
// An update runs in steps: the beat is registered, the chain compares
// against every cell and shifts, the best level is registered onto the result
// ports, and the result beat is handed over. The block takes one update at a
// time; a new beat is accepted the cycle after the previous result is taken.
// No clearing pass after reset.
`include "order_book_price_level_table_macros.svh"
module order_book_price_level_table import obpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_side,
   input  logic [31:0]           req_price_ticks,
   input  logic signed [31:0]    req_quantity,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_side_out,
   output logic                  rsp_best_valid,
   output logic [31:0]           rsp_best_price,
   output logic [30:0]           rsp_best_quantity,
   output logic                  rsp_dropped
);
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RESULT, S_OUT} state_type;
   state_type state_ff;
   upd_type   upd_ff;
   logic      drop_ff;
   cmd_type   cmd;
   logic [CNT_BITS-1:0] cnt [2], pos [2];
   logic                fnd [2];
   logic [PRICE_BITS-1:0] tp [2];
   logic [QTY_BITS-1:0]   tq [2];
   logic [CNT_BITS-1:0] n, p;
   logic f;

   assign req_ready = (state_ff == S_IDLE);

   assign n = cnt[upd_ff.is_ask];
   assign p = pos[upd_ff.is_ask];
   assign f = fnd[upd_ff.is_ask];

   always_comb begin
      cmd = '0;
      cmd.en       = (state_ff == S_EXEC);
      cmd.is_ask   = upd_ff.is_ask;
      cmd.price    = upd_ff.price;
      cmd.qty      = upd_ff.qty;
      cmd.pos      = p;
      if (upd_ff.negative) cmd.do_remove = f;
      else if (f) begin
         cmd.do_write  = 1'b1;
         cmd.do_remove = (upd_ff.qty == '0) && (p == '0);
      end else cmd.do_insert = (n < CNT_BITS'(LEVELS));
   end

   for (genvar s = 0; s < 2; s++) begin : g_side
      obpl_side u_side (
         .clock(clock), .reset(reset), .sel(upd_ff.is_ask == 1'(s)), .cmd(cmd),
         .count(cnt[s]), .pos(pos[s]), .found(fnd[s]), .top_price(tp[s]),
         .top_qty(tq[s])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               upd_ff.is_ask   <= req_side;
               upd_ff.price    <= req_price_ticks;
               upd_ff.qty      <= req_quantity[30:0];
               upd_ff.negative <= req_quantity[31];
               state_ff        <= S_EXEC;
            end
            S_EXEC: begin
               drop_ff  <= !upd_ff.negative && !f && (n >= CNT_BITS'(LEVELS));
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               rsp_side_out      <= upd_ff.is_ask;
               rsp_best_valid    <= (n != '0);
               rsp_best_price    <= (n != '0) ? tp[upd_ff.is_ask] : '0;
               rsp_best_quantity <= (n != '0) ? tq[upd_ff.is_ask] : '0;
               rsp_dropped       <= drop_ff;
               rsp_valid         <= 1'b1;
               state_ff          <= S_OUT;
            end
            S_OUT: if (rsp_ready) begin
               rsp_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `OBPL_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid && rsp_dropped, rsp_best_valid, "drop with empty side")
   `OBPL_ASSERT_IMP(a_cnt_bid, clock, reset, 1'b1, cnt[0] <= CNT_BITS'(LEVELS), "bid count overflow")
   `OBPL_ASSERT_IMP(a_cnt_ask, clock, reset, 1'b1, cnt[1] <= CNT_BITS'(LEVELS), "ask count overflow")
   `OBPL_ASSERT_NXT(a_accept, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accept lost")
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

class price_book_scoreboard;
   typedef struct {
      logic        side;
      logic        valid;
      logic [31:0] price;
      logic [30:0] qty;
      logic        dropped;
   } best_type;

   logic [31:0] lvl_price[2][$];
   logic [30:0] lvl_qty[2][$];
   best_type    pending_best[$];
   int          mismatches;

   function int count(int s);
      return lvl_price[s].size();
   endfunction

   function void note_update(logic side, logic [31:0] price, logic signed [31:0] quantity);
      int s, n, pos;
      bit found, drop, ahead;
      best_type b;
      s = side;
      n = lvl_price[s].size();
      pos = 0;
      drop = 0;
      while (pos < n) begin
         ahead = side ? (lvl_price[s][pos] < price) : (lvl_price[s][pos] > price);
         if (!ahead) break;
         pos++;
      end
      found = (pos < n) && (lvl_price[s][pos] == price);
      if (quantity[31]) begin
         if (found) begin
            lvl_price[s].delete(pos);
            lvl_qty[s].delete(pos);
         end
      end else if (found) begin
         lvl_qty[s][pos] = quantity[30:0];
         if (quantity[30:0] == 0 && pos == 0) begin
            lvl_price[s].delete(0);
            lvl_qty[s].delete(0);
         end
      end else if (n >= obpl_pkg::LEVELS) begin
         drop = 1;
      end else begin
         lvl_price[s].insert(pos, price);
         lvl_qty[s].insert(pos, quantity[30:0]);
      end
      b.side = side;
      b.dropped = drop;
      if (lvl_price[s].size() > 0) begin
         b.valid = 1;
         b.price = lvl_price[s][0];
         b.qty = lvl_qty[s][0];
      end else begin
         b.valid = 0;
         b.price = 0;
         b.qty = 0;
      end
      pending_best.push_back(b);
   endfunction

   function void check_best(logic side, logic valid, logic [31:0] price, logic [30:0] qty,
                            logic dropped);
      best_type e;
      if (pending_best.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected beat side=%0d price=%0d", side, price);
         return;
      end
      e = pending_best.pop_front();
      if (side !== e.side || valid !== e.valid || price !== e.price || qty !== e.qty
          || dropped !== e.dropped) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch exp s%0d v%0d p%0d q%0d d%0d got s%0d v%0d p%0d q%0d d%0d",
                     e.side, e.valid, e.price, e.qty, e.dropped,
                     side, valid, price, qty, dropped);
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_side = 0;
   logic [31:0] req_price_ticks = 0;
   logic signed [31:0] req_quantity = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_side_out;
   logic        rsp_best_valid;
   logic [31:0] rsp_best_price;
   logic [30:0] rsp_best_quantity;
   logic        rsp_dropped;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   price_book_scoreboard book = new();

   order_book_price_level_table uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            book.check_best(rsp_side_out, rsp_best_valid, rsp_best_price,
                            rsp_best_quantity, rsp_dropped);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // req_valid stays high between back-to-back beats; it drops only for idle cycles
   task automatic send_update(logic side, logic [31:0] price, logic signed [31:0] qty);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_side <= side;
      req_price_ticks <= price;
      req_quantity <= qty;
      book.note_update(side, price, qty);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_update(logic [31:0] base);
      logic side;
      logic [31:0] price;
      logic signed [31:0] qty;
      int r;
      side = $urandom_range(1);
      r = $urandom_range(99);
      if (r < 5) price = $urandom();
      else price = base + $urandom_range(90);
      r = $urandom_range(99);
      if (r < 20) qty = -($urandom_range(1000) + 1);
      else if (r < 25) qty = 32'sh8000_0000 | $urandom();
      else if (r < 35) qty = 0;
      else if (r < 45) qty = $urandom() & 32'h7fff_ffff;
      else qty = $urandom_range(5000);
      send_update(side, price, qty);
   endtask

   initial begin
      int i, ph;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_update(0, 100, 5);
      send_update(1, 200, 7);
      send_update(0, 32'hffff_ffff, 32'sh7fff_ffff);
      send_update(1, 0, 32'sh7fff_ffff);
      send_update(0, 0, 0);
      send_update(0, 50, 3);
      send_update(0, 50, 0);
      send_update(0, 32'hffff_ffff, 0);
      send_update(1, 999, 32'sh8000_0000);
      send_update(1, 0, -1);
      send_update(1, 200, -1);
      send_update(0, 100, -5);
      send_update(0, 0, -1);
      send_update(0, 50, -1);
      send_update(1, 300, 0);
      send_update(1, 300, 0);
      send_update(1, 300, -1);
      for (i = 0; i < 70; i++) send_update(1, 1000 + i, i + 1);
      send_update(1, 0, 4);
      send_update(1, 1000, -1);
      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 73 : 0;
         recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 38 : 0;
         for (i = 0; i < 420; i++) random_update(ph * 40 + 5000);
      end
      req_valid <= 0;
      while (book.pending_best.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.mismatches == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
